>>> src/enm_pkg.sv
// Package with types and constants for the endpoint nearest matcher.
`timescale 1ns / 1ps
package enm_pkg;
    localparam int MaxEnds = 32;
    localparam int IdxW = $clog2(MaxEnds);
    localparam int CntW = $clog2(MaxEnds + 1);
    localparam int CoordW = 16;
    localparam int DiffW = CoordW + 1;
    localparam int SqW = 2 * DiffW;
    localparam int DistW = SqW + 1;
    localparam logic [1:0] SideOwn = 2'd0;
    localparam logic [1:0] SideNbr = 2'd2;
    localparam logic [1:0] KindCross = 2'd0;
    localparam logic [1:0] KindOwn = 2'd1;
    localparam logic [1:0] KindNbr = 2'd2;
    localparam logic [1:0] KindNone = 2'd3;

    typedef struct packed {
        logic                     owner;
        logic [1:0]               side_label;
        logic [7:0]               end_id;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_z;
        logic                     load_done;
    } t_in_word;

    typedef struct packed {
        logic [1:0] pair_kind;
        logic [7:0] first_end;
        logic [7:0] second_end;
        logic       dropped_any;
        logic       final_pair;
    } t_out_word;

    typedef enum logic [3:0] {
        S_LOAD, S_CR_INIT, S_CR_RD, S_CR_CMP, S_CR_EMIT,
        S_PU_I, S_PU_RD, S_PU_CMP, S_PU_EMIT, S_NONE, S_WAIT
    } t_state;
endpackage

>>> src/enm_dist.sv
// Shared squared distance unit: reads two points, registers the differences, then the squares.
`timescale 1ns / 1ps
module enm_dist (
    input  logic                              i_clk,
    input  logic signed [enm_pkg::CoordW-1:0] i_ax,
    input  logic signed [enm_pkg::CoordW-1:0] i_az,
    input  logic signed [enm_pkg::CoordW-1:0] i_bx,
    input  logic signed [enm_pkg::CoordW-1:0] i_bz,
    output logic [enm_pkg::DistW-1:0]         o_dist
);
    import enm_pkg::*;
    logic signed [DiffW-1:0] r_dx, r_dz;
    logic [SqW-1:0] r_sx, r_sz;
    always_ff @(posedge i_clk) begin
        r_dx <= DiffW'(i_ax) - DiffW'(i_bx);
        r_dz <= DiffW'(i_az) - DiffW'(i_bz);
        r_sx <= SqW'(r_dx * r_dx);
        r_sz <= SqW'(r_dz * r_dz);
    end
    assign o_dist = DistW'(r_sx) + DistW'(r_sz);
endmodule

>>> src/endpoint_nearest_matcher.sv
// Top level of the endpoint nearest matcher: storage, sequencer, output register.
// Load: one word per cycle; o_ready is high only while loading.
// Match pass after load_done: one distance at a time through the shared unit,
// a cross pass of small set S against large set L, then a same-side pass within L.
// One pair is held back for final_pair; an emit stalls while the output word waits.
// Synchronous active-low reset clears counts, taken marks, overflow flag and output valid.
`timescale 1ns / 1ps
module endpoint_nearest_matcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  enm_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output enm_pkg::t_out_word o_data
);
    import enm_pkg::*;

    logic signed [CoordW-1:0] own_x [MaxEnds], own_z [MaxEnds];
    logic signed [CoordW-1:0] nbr_x [MaxEnds], nbr_z [MaxEnds];
    logic [7:0] own_ids [MaxEnds], nbr_ids [MaxEnds];
    t_state r_st, n_st;
    logic [CntW-1:0] r_own_cnt, n_own_cnt, r_nbr_cnt, n_nbr_cnt;
    logic [MaxEnds-1:0] r_own_tk, n_own_tk, r_nbr_tk, n_nbr_tk;
    logic r_ovf, n_ovf;
    logic [CntW-1:0] r_i, n_i, r_j, n_j;
    logic [IdxW-1:0] r_best, n_best;
    logic [DistW-1:0] r_bd, n_bd;
    logic r_found, n_found;
    logic r_wt, n_wt;
    logic r_swap, n_swap;
    logic r_pu, n_pu;
    logic r_hv, n_hv;
    logic r_ov, n_ov;
    t_out_word r_od, n_od, r_hold;
    logic ld_pt, ld_pair;
    logic signed [CoordW-1:0] r_ax, r_az, r_bx, r_bz;
    logic [DistW-1:0] sq_sum;
    logic [CntW-1:0] s_cnt, l_cnt;
    logic [MaxEnds-1:0] l_tk;
    logic [IdxW-1:0] ii, jj, bb;
    logic a_own;

    // small set S = swap ? own : nbr ; large set L
    assign s_cnt = r_swap ? r_own_cnt : r_nbr_cnt;
    assign l_cnt = r_swap ? r_nbr_cnt : r_own_cnt;
    assign l_tk = r_swap ? r_nbr_tk : r_own_tk;
    assign ii = r_i[IdxW-1:0];
    assign jj = r_j[IdxW-1:0];
    assign bb = r_best;
    assign a_own = r_pu ^ r_swap;

    enm_dist u_dist (.i_clk(i_clk), .i_ax(r_ax), .i_az(r_az), .i_bx(r_bx),
        .i_bz(r_bz), .o_dist(sq_sum));

    wire in_acc = i_valid && o_ready;
    wire keep_own = !i_data.owner && i_data.side_label == SideOwn;
    wire keep_nbr = i_data.owner && i_data.side_label == SideNbr;
    wire own_room = r_own_cnt < CntW'(MaxEnds);
    wire nbr_room = r_nbr_cnt < CntW'(MaxEnds);
    assign o_ready = (r_st == S_LOAD);
    assign o_valid = r_ov;
    assign o_data = r_od;
    wire out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (in_acc && keep_own && own_room) begin
            own_x[r_own_cnt[IdxW-1:0]] <= i_data.pos_x;
            own_z[r_own_cnt[IdxW-1:0]] <= i_data.pos_z;
            own_ids[r_own_cnt[IdxW-1:0]] <= i_data.end_id;
        end
        if (in_acc && keep_nbr && nbr_room) begin
            nbr_x[r_nbr_cnt[IdxW-1:0]] <= i_data.pos_x;
            nbr_z[r_nbr_cnt[IdxW-1:0]] <= i_data.pos_z;
            nbr_ids[r_nbr_cnt[IdxW-1:0]] <= i_data.end_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_pt) begin
            r_ax <= a_own ? own_x[ii] : nbr_x[ii];
            r_az <= a_own ? own_z[ii] : nbr_z[ii];
            r_bx <= r_swap ? nbr_x[jj] : own_x[jj];
            r_bz <= r_swap ? nbr_z[jj] : own_z[jj];
        end
        if (ld_pair) begin
            if (r_pu) begin
                r_hold.pair_kind <= r_swap ? KindNbr : KindOwn;
                r_hold.first_end <= r_swap ? nbr_ids[ii] : own_ids[ii];
                r_hold.second_end <= r_swap ? nbr_ids[bb] : own_ids[bb];
            end else begin
                r_hold.pair_kind <= KindCross;
                r_hold.first_end <= r_swap ? own_ids[ii] : own_ids[bb];
                r_hold.second_end <= r_swap ? nbr_ids[bb] : nbr_ids[ii];
            end
            r_hold.dropped_any <= r_ovf;
            r_hold.final_pair <= 1'b0;
        end
    end

    always_comb begin
        n_st = r_st;
        n_own_cnt = r_own_cnt;
        n_nbr_cnt = r_nbr_cnt;
        n_own_tk = r_own_tk;
        n_nbr_tk = r_nbr_tk;
        n_ovf = r_ovf;
        n_i = r_i;
        n_j = r_j;
        n_best = r_best;
        n_bd = r_bd;
        n_found = r_found;
        n_wt = r_wt;
        n_swap = r_swap;
        n_pu = r_pu;
        n_hv = r_hv;
        n_ov = r_ov;
        n_od = r_od;
        ld_pt = 1'b0;
        ld_pair = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            S_LOAD: if (in_acc) begin
                if (keep_own) begin
                    if (own_room) n_own_cnt = r_own_cnt + 1'b1;
                    else n_ovf = 1'b1;
                end
                if (keep_nbr) begin
                    if (nbr_room) n_nbr_cnt = r_nbr_cnt + 1'b1;
                    else n_ovf = 1'b1;
                end
                if (i_data.load_done) begin
                    n_st = S_CR_INIT;
                    n_i = '0;
                    n_pu = 1'b0;
                    n_hv = 1'b0;
                    n_swap = n_own_cnt < n_nbr_cnt;
                end
            end
            S_CR_INIT: begin
                n_found = 1'b0;
                n_j = '0;
                if (r_i < s_cnt) n_st = S_CR_RD;
                else begin
                    n_st = S_PU_I;
                    n_i = '0;
                    n_pu = 1'b1;
                end
            end
            S_CR_RD: begin
                if (r_j < l_cnt) begin
                    ld_pt = 1'b1;
                    n_wt = 1'b1;
                    n_st = S_WAIT;
                end else n_st = S_CR_EMIT;
            end
            S_WAIT: begin
                if (r_wt) n_wt = 1'b0;
                else n_st = r_pu ? S_PU_CMP : S_CR_CMP;
            end
            S_CR_CMP, S_PU_CMP: begin
                if (!r_found || sq_sum < r_bd) begin
                    n_found = 1'b1;
                    n_bd = sq_sum;
                    n_best = jj;
                end
                n_j = r_j + 1'b1;
                n_st = r_pu ? S_PU_RD : S_CR_RD;
            end
            S_CR_EMIT: if (!r_hv || out_free) begin
                if (r_hv) begin
                    n_ov = 1'b1;
                    n_od = r_hold;
                end
                ld_pair = 1'b1;
                n_hv = 1'b1;
                if (r_swap) begin
                    n_nbr_tk[bb] = 1'b1;
                    n_own_tk[ii] = 1'b1;
                end else begin
                    n_own_tk[bb] = 1'b1;
                    n_nbr_tk[ii] = 1'b1;
                end
                n_i = r_i + 1'b1;
                n_st = S_CR_INIT;
            end
            S_PU_I: begin
                n_found = 1'b0;
                n_j = r_i + 1'b1;
                if (r_i >= l_cnt) n_st = S_NONE;
                else if (l_tk[ii]) n_i = r_i + 1'b1;
                else n_st = S_PU_RD;
            end
            S_PU_RD: begin
                if (r_j >= l_cnt) n_st = S_PU_EMIT;
                else if (l_tk[jj]) n_j = r_j + 1'b1;
                else begin
                    ld_pt = 1'b1;
                    n_wt = 1'b1;
                    n_st = S_WAIT;
                end
            end
            S_PU_EMIT: begin
                if (!r_found) begin
                    n_i = r_i + 1'b1;
                    n_st = S_PU_I;
                end else if (!r_hv || out_free) begin
                    if (r_hv) begin
                        n_ov = 1'b1;
                        n_od = r_hold;
                    end
                    ld_pair = 1'b1;
                    n_hv = 1'b1;
                    if (r_swap) begin
                        n_nbr_tk[ii] = 1'b1;
                        n_nbr_tk[bb] = 1'b1;
                    end else begin
                        n_own_tk[ii] = 1'b1;
                        n_own_tk[bb] = 1'b1;
                    end
                    n_i = r_i + 1'b1;
                    n_st = S_PU_I;
                end
            end
            S_NONE: if (out_free) begin
                n_ov = 1'b1;
                if (r_hv) begin
                    n_od = r_hold;
                    n_od.final_pair = 1'b1;
                end else begin
                    n_od.pair_kind = KindNone;
                    n_od.first_end = '0;
                    n_od.second_end = '0;
                    n_od.dropped_any = r_ovf;
                    n_od.final_pair = 1'b1;
                end
                n_hv = 1'b0;
                n_own_cnt = '0;
                n_nbr_cnt = '0;
                n_own_tk = '0;
                n_nbr_tk = '0;
                n_ovf = 1'b0;
                n_st = S_LOAD;
            end
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_own_cnt <= '0;
            r_nbr_cnt <= '0;
            r_own_tk <= '0;
            r_nbr_tk <= '0;
            r_ovf <= 1'b0;
            r_ov <= 1'b0;
            r_od <= '0;
            r_hv <= 1'b0;
            r_pu <= 1'b0;
        end else begin
            r_st <= n_st;
            r_own_cnt <= n_own_cnt;
            r_nbr_cnt <= n_nbr_cnt;
            r_own_tk <= n_own_tk;
            r_nbr_tk <= n_nbr_tk;
            r_ovf <= n_ovf;
            r_ov <= n_ov;
            r_od <= n_od;
            r_hv <= n_hv;
            r_pu <= n_pu;
            r_i <= n_i;
            r_j <= n_j;
            r_best <= n_best;
            r_bd <= n_bd;
            r_found <= n_found;
            r_wt <= n_wt;
            r_swap <= n_swap;
        end
    end

`ifndef SYNTH
    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == S_LOAD) else $error("ready outside load");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_own_cnt <= CntW'(MaxEnds) && r_nbr_cnt <= CntW'(MaxEnds))
        else $error("count overrun");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_NONE && out_free) |=> r_own_cnt == '0 && !r_ovf)
        else $error("state not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_data))
        else $error("output word not held");
`endif
endmodule

>>> tb/tb_endpoint_nearest_matcher.sv
// Testbench for the endpoint nearest matcher: directed, overflow and random runs checked against a predictor.
`timescale 1ns / 1ps
module tb_endpoint_nearest_matcher;
    import enm_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    endpoint_nearest_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    localparam int WatchLimit = 20000;
    localparam int ExpDepth = 256;

    logic signed [CoordW-1:0] own_px[MaxEnds], own_pz[MaxEnds];
    logic signed [CoordW-1:0] nbr_px[MaxEnds], nbr_pz[MaxEnds];
    logic [7:0]         own_id[MaxEnds], nbr_id[MaxEnds];
    int                 n_own, n_nbr;
    bit                 overflowed;
    t_out_word          exp_words[ExpDepth];
    int                 exp_wr, exp_rd;
    int                 errors;
    int                 idle_cycles;
    bit                 rx_stall_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [DistW-1:0] sq_dist(logic signed [CoordW-1:0] ax,
                                                 logic signed [CoordW-1:0] az,
                                                 logic signed [CoordW-1:0] bx,
                                                 logic signed [CoordW-1:0] bz);
        logic signed [DiffW-1:0] dx, dz;
        logic [SqW-1:0] px, pz;
        dx = DiffW'(ax) - DiffW'(bx);
        dz = DiffW'(az) - DiffW'(bz);
        px = SqW'(dx) * SqW'(dx);
        pz = SqW'(dz) * SqW'(dz);
        return DistW'(px) + DistW'(pz);
    endfunction

    function automatic void push_pair(logic [1:0] kind, logic [7:0] a, logic [7:0] b);
        t_out_word w;
        w.pair_kind = kind;
        w.first_end = a;
        w.second_end = b;
        w.dropped_any = overflowed;
        w.final_pair = 1'b0;
        exp_words[exp_wr % ExpDepth] = w;
        exp_wr++;
    endfunction

    function automatic void predict_word(t_in_word w);
        bit own_big;
        int big_n, small_n, best, produced;
        logic [DistW-1:0] d, bd;
        logic signed [CoordW-1:0] sx, sz, lx[MaxEnds], lz[MaxEnds];
        logic [7:0] lid[MaxEnds];
        bit lused[MaxEnds];
        bit found;
        if (w.owner == 1'b0 && w.side_label == SideOwn) begin
            if (n_own < MaxEnds) begin
                own_px[n_own] = w.pos_x; own_pz[n_own] = w.pos_z; own_id[n_own] = w.end_id;
                n_own++;
            end else begin
                overflowed = 1'b1;
            end
        end else if (w.owner == 1'b1 && w.side_label == SideNbr) begin
            if (n_nbr < MaxEnds) begin
                nbr_px[n_nbr] = w.pos_x; nbr_pz[n_nbr] = w.pos_z; nbr_id[n_nbr] = w.end_id;
                n_nbr++;
            end else begin
                overflowed = 1'b1;
            end
        end
        if (!w.load_done) return;
        produced = 0;
        own_big = (n_own >= n_nbr);
        big_n = own_big ? n_own : n_nbr;
        small_n = own_big ? n_nbr : n_own;
        for (int k = 0; k < MaxEnds; k++) begin
            lx[k] = own_big ? own_px[k] : nbr_px[k];
            lz[k] = own_big ? own_pz[k] : nbr_pz[k];
            lid[k] = own_big ? own_id[k] : nbr_id[k];
            lused[k] = 1'b0;
        end
        for (int k = 0; k < small_n; k++) begin
            sx = own_big ? nbr_px[k] : own_px[k];
            sz = own_big ? nbr_pz[k] : own_pz[k];
            best = 0;
            bd = '0;
            for (int m = 0; m < big_n; m++) begin
                d = sq_dist(sx, sz, lx[m], lz[m]);
                if (m == 0 || d < bd) begin
                    best = m; bd = d;
                end
            end
            lused[best] = 1'b1;
            if (own_big) push_pair(KindCross, own_id[best], nbr_id[k]);
            else push_pair(KindCross, own_id[k], nbr_id[best]);
            produced++;
        end
        for (int i = 0; i < big_n; i++) begin
            if (lused[i]) continue;
            found = 1'b0; best = 0; bd = '0;
            for (int j = i + 1; j < big_n; j++) begin
                if (lused[j]) continue;
                d = sq_dist(lx[i], lz[i], lx[j], lz[j]);
                if (!found || d < bd) begin
                    found = 1'b1; best = j; bd = d;
                end
            end
            if (found) begin
                lused[i] = 1'b1; lused[best] = 1'b1;
                push_pair(own_big ? KindOwn : KindNbr, lid[i], lid[best]);
                produced++;
            end
        end
        if (produced == 0) push_pair(KindNone, 8'd0, 8'd0);
        exp_words[(exp_wr - 1) % ExpDepth].final_pair = 1'b1;
        n_own = 0;
        n_nbr = 0;
        overflowed = 1'b0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(t_in_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(w);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in_word make_end(bit own, logic [7:0] id, logic [CoordW-1:0] x,
                                          logic [CoordW-1:0] z, bit done);
        t_in_word w;
        w.owner = own ? 1'b0 : 1'b1;
        w.side_label = own ? SideOwn : SideNbr;
        w.end_id = id;
        w.pos_x = x;
        w.pos_z = z;
        w.load_done = done;
        return w;
    endfunction

    function automatic logic [CoordW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r < 5) return 16'($urandom_range(0, 15)) - 16'd8;
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        t_in_word w;
        send_word(make_end(1'b1, 8'd0, 16'h8000, 16'h8000, 1'b0));
        send_word(make_end(1'b1, 8'd255, 16'h7fff, 16'h7fff, 1'b0));
        send_word(make_end(1'b1, 8'd7, 16'h7fff, 16'h8000, 1'b0));
        send_word(make_end(1'b0, 8'd9, 16'h8000, 16'h7fff, 1'b0));
        send_word(make_end(1'b0, 8'd10, 16'h0000, 16'h0000, 1'b0));
        w = make_end(1'b0, 8'd200, 16'h1234, 16'h4321, 1'b0);
        w.side_label = SideOwn;
        send_word(w);
        w = make_end(1'b1, 8'd201, 16'h1234, 16'h4321, 1'b0);
        w.side_label = 2'd3;
        send_word(w);
        send_word(make_end(1'b0, 8'hAA, 16'h0005, 16'h0005, 1'b1));
        drain();
        send_word(make_end(1'b1, 8'h55, 16'h0001, 16'h0001, 1'b1));
        drain();
        w = make_end(1'b1, 8'h11, 16'h0, 16'h0, 1'b1);
        w.side_label = 2'd1;
        send_word(w);
        drain();
        send_word(make_end(1'b1, 8'd1, 16'h0010, 16'h0, 1'b0));
        send_word(make_end(1'b1, 8'd2, 16'hfff0, 16'h0, 1'b0));
        send_word(make_end(1'b1, 8'd3, 16'h0, 16'h0010, 1'b0));
        send_word(make_end(1'b0, 8'd4, 16'h0, 16'h0, 1'b1));
        drain();
    endtask

    task automatic test_overflow();
        for (int k = 0; k < MaxEnds + 3; k++)
            send_word(make_end(1'b1, 8'($urandom), rand_coord(), rand_coord(), 1'b0));
        for (int k = 0; k < MaxEnds + 2; k++)
            send_word(make_end(1'b0, 8'($urandom), rand_coord(), rand_coord(),
                               k == MaxEnds + 1));
        drain();
    endtask

    task automatic test_random_runs();
        t_in_word w;
        int total, len;
        total = 0;
        while (total < 376) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w.owner = 1'($urandom);
                    w.side_label = 2'($urandom);
                    w.end_id = 8'($urandom);
                    w.pos_x = 16'($urandom);
                    w.pos_z = 16'($urandom);
                end else begin
                    w = make_end(1'($urandom_range(0, 1)), 8'($urandom), rand_coord(),
                                 rand_coord(), 1'b0);
                end
                w.load_done = (k == len - 1);
                send_word(w);
                total++;
            end
            if ($urandom_range(0, 5) == 0) drain();
        end
        drain();
    endtask

    initial begin
        errors = 0;
        n_own = 0;
        n_nbr = 0;
        exp_wr = 0;
        exp_rd = 0;
        overflowed = 1'b0;
        rx_stall_on = 1'b1;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        rx_stall_on = 1'b0;
        test_overflow();
        rx_stall_on = 1'b1;
        test_random_runs();
        if (errors == 0) $display("endpoint_nearest_matcher verification clean");
        else $display("endpoint_nearest_matcher verification failed");
        $finish;
    end

    initial begin
        int hold;
        i_ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                hold = gap_len();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_rd == exp_wr) begin
                $error("pair word with nothing expected: %p", o_data);
                errors++;
            end else begin
                want = exp_words[exp_rd % ExpDepth];
                exp_rd++;
                if (o_data.pair_kind !== want.pair_kind) begin
                    $error("pair_kind expected %0d got %0d", want.pair_kind, o_data.pair_kind);
                    errors++;
                end
                if (o_data.first_end !== want.first_end) begin
                    $error("first_end expected %0d got %0d", want.first_end, o_data.first_end);
                    errors++;
                end
                if (o_data.second_end !== want.second_end) begin
                    $error("second_end expected %0d got %0d", want.second_end,
                           o_data.second_end);
                    errors++;
                end
                if (o_data.dropped_any !== want.dropped_any) begin
                    $error("dropped_any expected %0d got %0d", want.dropped_any,
                           o_data.dropped_any);
                    errors++;
                end
                if (o_data.final_pair !== want.final_pair) begin
                    $error("final_pair expected %0d got %0d", want.final_pair,
                           o_data.final_pair);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("endpoint_nearest_matcher verification failed");
            $finish;
        end
    end

    initial idle_cycles = 0;
endmodule
